### src/dfifo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfifo_pkg
// Shared widths, action codes, command/status types and the slot count
// rounding for the drop-on-full frame FIFO.
// ----------------------------------------------------------------------------
package dfifo_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int FRAME_BITS_DEF = 64;

  localparam int ACT_W   = 3;
  localparam int FRAME_W = 64;
  localparam int LIMIT_W = 7;
  localparam int COUNT_W = 7;
  localparam int TOTAL_W = 32;

  localparam logic [ACT_W-1:0] ACT_PUSH  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_POP   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_PEEK  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_DRAIN = 3'd3;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 3'd4;

  typedef enum logic [2:0] {
    OP_PUSH,
    OP_POP,
    OP_PEEK,
    OP_DRAIN,
    OP_CLEAR,
    OP_STATUS
  } dp_op_t;

  typedef struct packed {
    logic   capture;
    logic   rd_peek;
    logic   load;
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic drain_last;
    logic out_free;
  } dp_stat_t;

  // Number of slots: depth rounded up to a power of two, in 2 to 128.
  function automatic int fifo_cap(input int depth);
    int c;
    begin
      c = 2;
      for (int k = 0; k < 6; k++) begin
        if (c < depth) begin
          c = c * 2;
        end
      end
      return c;
    end
  endfunction

endpackage

### src/dfifo_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfifo_if
// Request channel and result channel of the frame FIFO, valid/ready each.
// ----------------------------------------------------------------------------
interface dfifo_in_if;
  import dfifo_pkg::*;

  logic               valid;
  logic               ready;
  logic [ACT_W-1:0]   action;
  logic [FRAME_W-1:0] frame_in;
  logic [LIMIT_W-1:0] drain_limit;

  modport source (output valid, action, frame_in, drain_limit, input ready);
  modport sink   (input valid, action, frame_in, drain_limit, output ready);
endinterface

interface dfifo_out_if;
  import dfifo_pkg::*;

  logic               valid;
  logic               ready;
  logic [FRAME_W-1:0] frame_out;
  logic               frame_valid;
  logic               accepted;
  logic               last;
  logic [COUNT_W-1:0] moved_count;
  logic [COUNT_W-1:0] occupancy;
  logic               is_full;
  logic               is_empty;
  logic [TOTAL_W-1:0] pushed_total;
  logic [TOTAL_W-1:0] popped_total;
  logic [TOTAL_W-1:0] dropped_total;

  modport source (
    output valid, frame_out, frame_valid, accepted, last, moved_count, occupancy,
           is_full, is_empty, pushed_total, popped_total, dropped_total,
    input  ready
  );
  modport sink (
    input  valid, frame_out, frame_valid, accepted, last, moved_count, occupancy,
           is_full, is_empty, pushed_total, popped_total, dropped_total,
    output ready
  );
endinterface

### src/drop_on_full_frame_fifo_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drop_on_full_frame_fifo_top
// Circular frame FIFO with drop-on-full push, pop, peek, drain and clear.
// ----------------------------------------------------------------------------
// Channel   Dir   Handshake      Payload
// in_ch     in    valid/ready    action, frame_in, drain_limit
// out_ch    out   valid/ready    frame_out, flags, counts and totals
//
// Push, pop, peek and clear take the request and issue the slot read,
// then load the result register.
// A drain takes the request, then moves one frame per cycle through the
// registered slot memory read port while the result register is free.
// Synchronous reset zeroes the totals and occupancy; slots need no clearing.
// A stalled result holds in the output register; the next request is taken
// while it waits, and execution waits for the register to free.
// ----------------------------------------------------------------------------
module drop_on_full_frame_fifo_top #(
  parameter int DEPTH      = dfifo_pkg::DEPTH_DEF,
  parameter int FRAME_BITS = dfifo_pkg::FRAME_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  dfifo_in_if.sink    in_ch,
  dfifo_out_if.source out_ch
);
  import dfifo_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  dfifo_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .cmd   (cmd),
    .stat  (stat)
  );

  dfifo_dp #(
    .DEPTH      (DEPTH),
    .FRAME_BITS (FRAME_BITS)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cmd    (cmd),
    .stat   (stat)
  );

endmodule

### src/dfifo_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfifo_ctrl
// Controller: takes one request, then steps the datapath through the
// results that the request causes.
// ----------------------------------------------------------------------------
module dfifo_ctrl (
  input  logic               clk,
  input  logic               rst,
  dfifo_in_if.sink           in_ch,
  output dfifo_pkg::dp_cmd_t cmd,
  input  dfifo_pkg::dp_stat_t stat
);
  import dfifo_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [ACT_W-1:0] act;
  dp_op_t           op_dec;

  assign in_ch.ready = (state == S_IDLE);

  always_comb begin
    unique case (act)
      ACT_PUSH:  op_dec = OP_PUSH;
      ACT_POP:   op_dec = OP_POP;
      ACT_PEEK:  op_dec = OP_PEEK;
      ACT_DRAIN: op_dec = OP_DRAIN;
      ACT_CLEAR: op_dec = OP_CLEAR;
      default:   op_dec = OP_STATUS;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.op     = OP_STATUS;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        // The memory read for the first result is issued while the request
        // is taken, so its data is ready in the execute cycle.
        cmd.rd_peek = (in_ch.action == ACT_PEEK);
        if (in_ch.valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.rd_peek = (act == ACT_PEEK);
        if (stat.out_free) begin
          cmd.load = 1'b1;
          cmd.op   = op_dec;
          if (!(act == ACT_DRAIN && !stat.empty && !stat.drain_last)) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      act   <= ACT_PUSH;
    end else begin
      state <= state_next;
      if (cmd.capture) begin
        act <= in_ch.action;
      end
    end
  end

endmodule

### src/dfifo_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfifo_dp
// Datapath: slot memory, wrapping totals, occupancy, drain counter and the
// result register.
// ----------------------------------------------------------------------------
module dfifo_dp #(
  parameter int DEPTH      = dfifo_pkg::DEPTH_DEF,
  parameter int FRAME_BITS = dfifo_pkg::FRAME_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  dfifo_in_if.sink            in_ch,
  dfifo_out_if.source         out_ch,
  input  dfifo_pkg::dp_cmd_t  cmd,
  output dfifo_pkg::dp_stat_t stat
);
  import dfifo_pkg::*;

  localparam int CAP   = fifo_cap(DEPTH);
  localparam int IDX_W = $clog2(CAP);

  logic [FRAME_BITS-1:0] mem [CAP];
  logic [FRAME_BITS-1:0] rd_data;
  logic [IDX_W-1:0]      rd_addr;
  logic                  wr_en;

  logic [FRAME_BITS-1:0] frame_op;
  logic [LIMIT_W-1:0]    limit_op;
  logic [LIMIT_W-1:0]    moved;
  logic [LIMIT_W-1:0]    moved_next;
  logic [LIMIT_W-1:0]    moved_inc;

  logic [TOTAL_W-1:0] write_count, write_count_next;
  logic [TOTAL_W-1:0] read_count, read_count_next;
  logic [TOTAL_W-1:0] drop_count, drop_count_next;
  logic [COUNT_W-1:0] occ, occ_next;

  logic empty, full, drain_last;

  logic               out_valid;
  logic [FRAME_W-1:0] fo, fo_next;
  logic               fv, fv_next;
  logic               acc, acc_next;
  logic               lst, lst_next;
  logic [COUNT_W-1:0] mc, mc_next;
  logic [COUNT_W-1:0] occ_out;
  logic [TOTAL_W-1:0] pushed_out, popped_out, dropped_out;

  assign empty      = (occ == '0);
  assign full       = (occ == COUNT_W'(CAP));
  assign moved_inc  = moved + LIMIT_W'(1);
  // The drain ends when the last held frame goes or the limit is reached.
  assign drain_last = (occ == COUNT_W'(1)) || (limit_op != '0 && moved_inc == limit_op);

  assign stat.empty      = empty;
  assign stat.drain_last = drain_last;
  assign stat.out_free   = !out_valid || out_ch.ready;

  always_comb begin
    write_count_next = write_count;
    read_count_next  = read_count;
    drop_count_next  = drop_count;
    occ_next         = occ;
    moved_next       = moved;
    wr_en            = 1'b0;
    fo_next          = '0;
    fv_next          = 1'b0;
    acc_next         = 1'b0;
    lst_next         = 1'b1;
    mc_next          = '0;
    if (cmd.capture) begin
      moved_next = '0;
    end
    if (cmd.load) begin
      unique case (cmd.op)
        OP_PUSH: begin
          if (full) begin
            drop_count_next = drop_count + TOTAL_W'(1);
          end else begin
            wr_en            = 1'b1;
            write_count_next = write_count + TOTAL_W'(1);
            occ_next         = occ + COUNT_W'(1);
            acc_next         = 1'b1;
          end
        end
        OP_POP: begin
          if (!empty) begin
            read_count_next = read_count + TOTAL_W'(1);
            occ_next        = occ - COUNT_W'(1);
            fo_next         = FRAME_W'(rd_data);
            fv_next         = 1'b1;
          end
        end
        OP_PEEK: begin
          if (!empty) begin
            fo_next = FRAME_W'(rd_data);
            fv_next = 1'b1;
          end
        end
        OP_DRAIN: begin
          if (!empty) begin
            read_count_next = read_count + TOTAL_W'(1);
            occ_next        = occ - COUNT_W'(1);
            fo_next         = FRAME_W'(rd_data);
            fv_next         = 1'b1;
            moved_next      = moved_inc;
            mc_next         = COUNT_W'(moved_inc);
            lst_next        = drain_last;
          end
        end
        OP_CLEAR: begin
          read_count_next = write_count;
          occ_next        = '0;
        end
        OP_STATUS: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Reading the next read pointer drains a frame per cycle if not stalled.
  assign rd_addr = cmd.rd_peek ? IDX_W'(write_count - TOTAL_W'(1))
                               : read_count_next[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[write_count[IDX_W-1:0]] <= frame_op;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_count <= '0;
      read_count  <= '0;
      drop_count  <= '0;
      occ         <= '0;
      moved       <= '0;
      out_valid   <= 1'b0;
    end else begin
      write_count <= write_count_next;
      read_count  <= read_count_next;
      drop_count  <= drop_count_next;
      occ         <= occ_next;
      moved       <= moved_next;
      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      frame_op <= in_ch.frame_in[FRAME_BITS-1:0];
      limit_op <= in_ch.drain_limit;
    end
    if (cmd.load) begin
      fo          <= fo_next;
      fv          <= fv_next;
      acc         <= acc_next;
      lst         <= lst_next;
      mc          <= mc_next;
      occ_out     <= occ_next;
      pushed_out  <= write_count_next;
      popped_out  <= read_count_next;
      dropped_out <= drop_count_next;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.frame_out     = fo;
  assign out_ch.frame_valid   = fv;
  assign out_ch.accepted      = acc;
  assign out_ch.last          = lst;
  assign out_ch.moved_count   = mc;
  assign out_ch.occupancy     = occ_out;
  assign out_ch.is_full       = (occ_out == COUNT_W'(CAP));
  assign out_ch.is_empty      = (occ_out == '0);
  assign out_ch.pushed_total  = pushed_out;
  assign out_ch.popped_total  = popped_out;
  assign out_ch.dropped_total = dropped_out;

endmodule

### src/dfifo_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfifo_checker
// Port-level checks on the frame FIFO, bound to the top level.
// ----------------------------------------------------------------------------
module dfifo_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [dfifo_pkg::FRAME_W-1:0] frame_out,
  input logic                          frame_valid,
  input logic                          accepted,
  input logic                          is_empty,
  input logic [dfifo_pkg::COUNT_W-1:0] moved_count
);
  import dfifo_pkg::*;

  // A stalled result keeps its payload.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(frame_out) && $stable(moved_count))
    else $error("stalled result changed");

  // A stored push leaves at least one frame and carries no frame.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && accepted |-> !is_empty && !frame_valid)
    else $error("push result inconsistent");

  // Only a drain that moved a frame reports a moved count.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && moved_count != '0 |-> frame_valid)
    else $error("moved count without frame");

  // One request at a time: the input closes once a request is taken.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind drop_on_full_frame_fifo_top dfifo_checker u_dfifo_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .frame_out   (out_ch.frame_out),
  .frame_valid (out_ch.frame_valid),
  .accepted    (out_ch.accepted),
  .is_empty    (out_ch.is_empty),
  .moved_count (out_ch.moved_count)
);

### tb/sv/drop_on_full_frame_fifo_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drop_on_full_frame_fifo_top_tb
// Self-checking bench for the drop-on-full frame FIFO. A queue of requests
// is filled with directed corner cases and then with random action
// sequences. A valid/ready driver sends them, and a scoreboard keeps its own
// copy of the slots and totals. Every result is checked field by field,
// with random stalls on both channels.
// ----------------------------------------------------------------------------
module drop_on_full_frame_fifo_top_tb;
  import dfifo_pkg::*;

  localparam int DEPTH         = 16;
  localparam int SLOTS         = 16;
  localparam int IDX_W         = $clog2(SLOTS);
  localparam int RANDOM_REQS   = 200;
  localparam int HOLD_AT       = 60;
  localparam int HOLD_CYCLES   = 120;
  localparam int SETTLE_CYCLES = 40;
  localparam int MAX_REPORTS   = 40;
  localparam int CYCLE_LIMIT   = 400000;

  // Action codes that the block does not define.
  localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd5;
  localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;

  typedef struct {
    logic [ACT_W-1:0]   action;
    logic [FRAME_W-1:0] frame;
    logic [LIMIT_W-1:0] limit;
    int unsigned        gap;
    bit                 after_idle;
  } fifo_req_t;

  typedef struct {
    logic [FRAME_W-1:0] frame_out;
    logic               frame_valid;
    logic               accepted;
    logic               last;
    logic [COUNT_W-1:0] moved_count;
    logic [COUNT_W-1:0] occupancy;
    logic               is_full;
    logic               is_empty;
    logic [TOTAL_W-1:0] pushed_total;
    logic [TOTAL_W-1:0] popped_total;
    logic [TOTAL_W-1:0] dropped_total;
  } fifo_res_t;

  logic clk;
  logic rst = 1'b1;

  dfifo_in_if  in_ch ();
  dfifo_out_if out_ch ();

  drop_on_full_frame_fifo_top #(
    .DEPTH      (DEPTH),
    .FRAME_BITS (FRAME_W)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  fifo_req_t          req_q[$];
  fifo_res_t          owed_q[$];
  fifo_req_t          cur_req;
  logic [FRAME_W-1:0] slot_mem [SLOTS];
  logic [TOTAL_W-1:0] wr_total   = '0;
  logic [TOTAL_W-1:0] rd_total   = '0;
  logic [TOTAL_W-1:0] drop_total = '0;
  int unsigned        err_cnt    = 0;
  int unsigned        taken_cnt  = 0;
  int unsigned        total_reqs = 0;
  int unsigned        cycle_cnt  = 0;
  int unsigned        idle_waited = 0;
  int unsigned        hold_left  = 0;
  int unsigned        stall_left = 0;
  bit                 hold_done  = 1'b0;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r < 8) begin
      return 0;
    end else if (r < 14) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic void add_request(logic [ACT_W-1:0] action, logic [FRAME_W-1:0] frame,
                                      logic [LIMIT_W-1:0] limit, int unsigned gap,
                                      bit after_idle);
    fifo_req_t r;
    r.action     = action;
    r.frame      = frame;
    r.limit      = limit;
    r.gap        = gap;
    r.after_idle = after_idle;
    req_q.insert(req_q.size(), r);
  endfunction

  // Status fields are taken after the action has changed the counts.
  function automatic void owe_result(logic [FRAME_W-1:0] frame, logic fvalid, logic acc,
                                     logic lst, logic [COUNT_W-1:0] moved);
    fifo_res_t          r;
    logic [TOTAL_W-1:0] held;
    held            = wr_total - rd_total;
    r.frame_out     = frame;
    r.frame_valid   = fvalid;
    r.accepted      = acc;
    r.last          = lst;
    r.moved_count   = moved;
    r.occupancy     = held[COUNT_W-1:0];
    r.is_full       = (held >= SLOTS);
    r.is_empty      = (held == 0);
    r.pushed_total  = wr_total;
    r.popped_total  = rd_total;
    r.dropped_total = drop_total;
    owed_q.insert(owed_q.size(), r);
  endfunction

  function automatic void apply_request(fifo_req_t q);
    logic [TOTAL_W-1:0] held;
    logic [FRAME_W-1:0] f;
    int unsigned        n;
    held = wr_total - rd_total;
    case (q.action)
      ACT_PUSH: begin
        if (held >= SLOTS) begin
          drop_total = drop_total + TOTAL_W'(1);
          owe_result('0, 1'b0, 1'b0, 1'b1, '0);
        end else begin
          slot_mem[wr_total[IDX_W-1:0]] = q.frame;
          wr_total = wr_total + TOTAL_W'(1);
          owe_result('0, 1'b0, 1'b1, 1'b1, '0);
        end
      end
      ACT_POP: begin
        if (held == 0) begin
          owe_result('0, 1'b0, 1'b0, 1'b1, '0);
        end else begin
          f = slot_mem[rd_total[IDX_W-1:0]];
          rd_total = rd_total + TOTAL_W'(1);
          owe_result(f, 1'b1, 1'b0, 1'b1, '0);
        end
      end
      ACT_PEEK: begin
        if (held == 0) begin
          owe_result('0, 1'b0, 1'b0, 1'b1, '0);
        end else begin
          f = slot_mem[IDX_W'(wr_total - TOTAL_W'(1))];
          owe_result(f, 1'b1, 1'b0, 1'b1, '0);
        end
      end
      ACT_DRAIN: begin
        n = held;
        if (q.limit != '0 && 32'(q.limit) < n) begin
          n = 32'(q.limit);
        end
        if (n > SLOTS) begin
          n = SLOTS;
        end
        if (n == 0) begin
          owe_result('0, 1'b0, 1'b0, 1'b1, '0);
        end
        for (int unsigned i = 0; i < n; i++) begin
          f = slot_mem[rd_total[IDX_W-1:0]];
          rd_total = rd_total + TOTAL_W'(1);
          owe_result(f, 1'b1, 1'b0, (i + 1 == n), COUNT_W'(i + 1));
        end
      end
      ACT_CLEAR: begin
        rd_total = wr_total;
        owe_result('0, 1'b0, 1'b0, 1'b1, '0);
      end
      default: begin
        owe_result('0, 1'b0, 1'b0, 1'b1, '0);
      end
    endcase
  endfunction

  function automatic void field_ok(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      if (err_cnt < MAX_REPORTS) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
      err_cnt++;
    end
  endfunction

  // Request driver.
  always @(posedge clk) begin
    logic vld_next;
    if (rst) begin
      in_ch.valid <= 1'b0;
      idle_waited = 0;
    end else begin
      vld_next = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        apply_request(cur_req);
        taken_cnt++;
        vld_next = 1'b0;
      end
      if (!vld_next && req_q.size() != 0) begin
        if (idle_waited < req_q[0].gap) begin
          idle_waited++;
        end else if (!(req_q[0].after_idle && owed_q.size() != 0)) begin
          cur_req = req_q.pop_front();
          in_ch.action      <= cur_req.action;
          in_ch.frame_in    <= cur_req.frame;
          in_ch.drain_limit <= cur_req.limit;
          vld_next    = 1'b1;
          idle_waited = 0;
        end
      end
      in_ch.valid <= vld_next;
    end
  end

  // Result monitor and output back-pressure.
  always @(posedge clk) begin
    fifo_res_t want;
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, owed_q.size());
      $display("drop_on_full_frame_fifo_top verification failed");
      $finish;
    end
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (owed_q.size() == 0) begin
          if (err_cnt < MAX_REPORTS) begin
            $display("%0t: unexpected result, expected none, actual frame %0h last %0b",
                     $time, out_ch.frame_out, out_ch.last);
          end
          err_cnt++;
        end else begin
          want = owed_q.pop_front();
          field_ok("frame_out", want.frame_out, out_ch.frame_out);
          field_ok("frame_valid", 64'(want.frame_valid), 64'(out_ch.frame_valid));
          field_ok("accepted", 64'(want.accepted), 64'(out_ch.accepted));
          field_ok("last", 64'(want.last), 64'(out_ch.last));
          field_ok("moved_count", 64'(want.moved_count), 64'(out_ch.moved_count));
          field_ok("occupancy", 64'(want.occupancy), 64'(out_ch.occupancy));
          field_ok("is_full", 64'(want.is_full), 64'(out_ch.is_full));
          field_ok("is_empty", 64'(want.is_empty), 64'(out_ch.is_empty));
          field_ok("pushed_total", 64'(want.pushed_total), 64'(out_ch.pushed_total));
          field_ok("popped_total", 64'(want.popped_total), 64'(out_ch.popped_total));
          field_ok("dropped_total", 64'(want.dropped_total), 64'(out_ch.dropped_total));
        end
      end
      // One long hold-off lets the FIFO back up and stall the request side.
      if (!hold_done && taken_cnt >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if ((cycle_cnt / 128) % 4 != 0 && $urandom_range(0, 3) == 0) begin
          stall_left = pick_gap();
        end
      end
    end
  end

  initial begin
    logic [ACT_W-1:0] act;
    logic [LIMIT_W-1:0] lim;
    int unsigned phase;
    int unsigned r;
    bit burst;

    in_ch.valid       = 1'b0;
    in_ch.action      = ACT_PUSH;
    in_ch.frame_in    = '0;
    in_ch.drain_limit = '0;
    out_ch.ready      = 1'b0;

    // Empty FIFO cases, undefined action codes, then a push and a clear.
    add_request(ACT_POP, '0, '0, 0, 1'b0);
    add_request(ACT_PEEK, '1, '0, 0, 1'b0);
    add_request(ACT_DRAIN, '0, '0, 0, 1'b0);
    add_request(ACT_SPARE_LO, '1, '1, 1, 1'b0);
    add_request(ACT_SPARE_HI, '0, '0, 0, 1'b0);
    add_request(ACT_PUSH, '1, '0, 0, 1'b0);
    add_request(ACT_CLEAR, '0, '0, 2, 1'b0);
    // Fill to capacity, drop one push as full, then peek, pop and drain 3.
    add_request(ACT_PUSH, '0, '0, 0, 1'b0);
    add_request(ACT_PUSH, '1, '0, 0, 1'b0);
    for (int i = 0; i < SLOTS - 3; i++) begin
      add_request(ACT_PUSH, {$urandom, $urandom}, '0, 0, 1'b0);
    end
    add_request(ACT_PUSH, 64'h5555_aaaa_0f0f_f0f0, '0, 0, 1'b0);
    add_request(ACT_PUSH, '1, '0, 0, 1'b0);
    add_request(ACT_PEEK, '0, '0, 0, 1'b0);
    add_request(ACT_POP, '0, '0, 0, 1'b0);
    add_request(ACT_DRAIN, '0, 7'd3, 0, 1'b0);
    // A limit above the occupancy drains everything that is held.
    add_request(ACT_DRAIN, '0, '1, 0, 1'b0);

    // Random phases: filling, emptying, mixed traffic and raw noise.
    for (int i = 0; i < RANDOM_REQS; i++) begin
      if (i % 20 == 0) begin
        phase = $urandom_range(0, 4);
        burst = ($urandom_range(0, 2) == 0);
      end
      r = $urandom_range(0, 99);
      case (phase)
        0: act = (r < 75) ? ACT_PUSH : (r < 85) ? ACT_PEEK : ACT_POP;
        1: act = (r < 30) ? ACT_DRAIN : (r < 65) ? ACT_POP : (r < 80) ? ACT_PEEK :
                 (r < 90) ? ACT_PUSH : ACT_CLEAR;
        3: act = ACT_W'($urandom_range(0, 7));
        default: act = (r < 45) ? ACT_PUSH : (r < 70) ? ACT_POP : (r < 85) ? ACT_DRAIN :
                       (r < 95) ? ACT_PEEK : ACT_CLEAR;
      endcase
      lim = ($urandom_range(0, 3) == 0) ? LIMIT_W'($urandom_range(0, 127)) :
                                          LIMIT_W'($urandom_range(0, 6));
      add_request(act, {$urandom, $urandom}, lim, burst ? 0 : pick_gap(), (i % 80 == 0));
    end
    total_reqs = req_q.size();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (taken_cnt != total_reqs) @(posedge clk);
    while (owed_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("drop_on_full_frame_fifo_top verification clean");
    end else begin
      $display("drop_on_full_frame_fifo_top verification failed");
    end
    $finish;
  end

endmodule
